### hdl/drive_control_word_handshake_macros.svh
// Assertion macros shared by the drive control-word handshake RTL.
`ifndef DRIVE_CONTROL_WORD_HANDSHAKE_MACROS_SVH
`define DRIVE_CONTROL_WORD_HANDSHAKE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked while reset is released.
`define DCWH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dcwh same-cycle check failed");
// Next-cycle implication, checked while reset is released.
`define DCWH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dcwh next-cycle check failed");
`else
`define DCWH_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DCWH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/dcwh_pkg.sv
// Types, constants and packing helpers for the drive control-word handshake.
`default_nettype none
package dcwh_pkg;

  localparam int unsigned IdW      = 11;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CmdW     = 7;
  localparam int unsigned CfgDataW = 11;

  localparam logic [IdW-1:0] StatusIdReset = 11'h181;

  // Command bit positions.
  localparam int unsigned CmdOn     = 0;
  localparam int unsigned CmdOff2   = 1;
  localparam int unsigned CmdOff3   = 2;
  localparam int unsigned CmdEnable = 3;
  localparam int unsigned CmdReset  = 4;
  localparam int unsigned CmdDrive  = 5;
  localparam int unsigned CmdToggle = 6;

  // Status byte 0 bit positions.
  localparam int unsigned StPowerUp = 0;
  localparam int unsigned StReady   = 1;
  localparam int unsigned StOpEn    = 2;
  localparam int unsigned StFault   = 3;
  localparam int unsigned StNoOff2  = 4;
  localparam int unsigned StNoOff3  = 5;
  localparam int unsigned StInhibit = 6;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_STATUS_ID      = 1'b0,
    CFG_READY_TO_DRIVE = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [IdW-1:0] status_frame_id;
    logic           ready_to_drive;
  } cfg_t;

  typedef struct packed {
    logic            fault_pending;
    logic [CmdW-1:0] cmd;
  } drv_state_t;

  // Control byte 0: on, off2, off3, enable in bits 0-3, reset in bit 7.
  function automatic logic [ByteW-1:0] pack_low(input logic [CmdW-1:0] c);
    pack_low = {c[CmdReset], 3'b000, c[CmdEnable], c[CmdOff3], c[CmdOff2], c[CmdOn]};
  endfunction

  // Control byte 1: drive in bit 1, toggle in bit 7.
  function automatic logic [ByteW-1:0] pack_high(input logic [CmdW-1:0] c);
    pack_high = {c[CmdToggle], 5'b00000, c[CmdDrive], 1'b0};
  endfunction

endpackage
`default_nettype wire

### hdl/dcwh_cfg.sv
// Configuration registers: status frame identifier and ready-to-drive permit.
`default_nettype none
module dcwh_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [0:0]                   cfg_index_i,
  input  wire logic [dcwh_pkg::CfgDataW-1:0] cfg_wdata_i,
  output dcwh_pkg::cfg_t                    cfg_o
);

  dcwh_pkg::cfg_t cfg_q;

  // Register writes; every index of the port maps to a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.status_frame_id <= dcwh_pkg::StatusIdReset;
      cfg_q.ready_to_drive  <= 1'b0;
    end else if (cfg_we_i) begin
      case (dcwh_pkg::cfg_index_e'(cfg_index_i))
        dcwh_pkg::CFG_STATUS_ID:      cfg_q.status_frame_id <= cfg_wdata_i[dcwh_pkg::IdW-1:0];
        dcwh_pkg::CFG_READY_TO_DRIVE: cfg_q.ready_to_drive  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### hdl/dcwh_decide.sv
// Next command bits and fault flag from the current state and one status byte.
`default_nettype none
module dcwh_decide (
  input  wire dcwh_pkg::drv_state_t       state_i,
  input  wire logic [dcwh_pkg::ByteW-1:0] status_i,
  input  wire logic                       ready_to_drive_i,
  output dcwh_pkg::drv_state_t            state_o
);

  logic pur, rdy, ope, flt, inh, offs_ok;

  assign pur     = status_i[dcwh_pkg::StPowerUp];
  assign rdy     = status_i[dcwh_pkg::StReady];
  assign ope     = status_i[dcwh_pkg::StOpEn];
  assign flt     = status_i[dcwh_pkg::StFault];
  assign inh     = status_i[dcwh_pkg::StInhibit];
  assign offs_ok = status_i[dcwh_pkg::StNoOff2] & status_i[dcwh_pkg::StNoOff3];

  // Priority chain of the status word state machine; toggle always flips.
  always_comb begin
    state_o = state_i;
    state_o.cmd[dcwh_pkg::CmdToggle] = ~state_i.cmd[dcwh_pkg::CmdToggle];
    if (state_i.fault_pending) begin
      // Acknowledge the earlier fault.
      state_o.cmd[dcwh_pkg::CmdReset] = ~state_i.cmd[dcwh_pkg::CmdReset];
      state_o.cmd[dcwh_pkg::CmdDrive] = 1'b0;
      state_o.fault_pending = 1'b0;
    end else if (flt) begin
      state_o.cmd[dcwh_pkg::CmdReset]  = ~state_i.cmd[dcwh_pkg::CmdReset];
      state_o.cmd[dcwh_pkg::CmdOn]     = 1'b0;
      state_o.cmd[dcwh_pkg::CmdOff2]   = 1'b0;
      state_o.cmd[dcwh_pkg::CmdOff3]   = 1'b0;
      state_o.cmd[dcwh_pkg::CmdEnable] = 1'b0;
      state_o.cmd[dcwh_pkg::CmdDrive]  = 1'b0;
      state_o.fault_pending = 1'b1;
    end else if (!pur && !rdy && !ope && (inh || offs_ok)) begin
      // Switch-on inhibit or not ready.
      state_o.cmd[dcwh_pkg::CmdOff2]  = 1'b1;
      state_o.cmd[dcwh_pkg::CmdOff3]  = 1'b1;
      state_o.cmd[dcwh_pkg::CmdOn]    = 1'b0;
      state_o.cmd[dcwh_pkg::CmdDrive] = 1'b0;
    end else if (!inh && pur && !rdy && !ope && offs_ok) begin
      // Ready to switch on, gated by the ready-to-drive permit.
      state_o.cmd[dcwh_pkg::CmdOff2] = 1'b1;
      state_o.cmd[dcwh_pkg::CmdOff3] = 1'b1;
      if (ready_to_drive_i) begin
        state_o.cmd[dcwh_pkg::CmdOn] = 1'b1;
      end else begin
        state_o.cmd[dcwh_pkg::CmdOn]    = 1'b0;
        state_o.cmd[dcwh_pkg::CmdDrive] = 1'b0;
      end
    end else if (!inh && pur && rdy && offs_ok) begin
      // Ready or operation enabled.
      state_o.cmd[dcwh_pkg::CmdOn]     = 1'b1;
      state_o.cmd[dcwh_pkg::CmdOff2]   = 1'b1;
      state_o.cmd[dcwh_pkg::CmdOff3]   = 1'b1;
      state_o.cmd[dcwh_pkg::CmdEnable] = 1'b1;
      state_o.cmd[dcwh_pkg::CmdDrive]  = 1'b1;
    end
  end

endmodule
`default_nettype wire

### hdl/drive_control_word_handshake.sv
// Top level of the drive control-word handshake: request pipeline and state.
//
// Each request is one received frame. It is captured in an input register, and
// the status decision then runs on it in a single pass and loads the result
// register together with the command state. A new request is taken in every
// cycle while the result side keeps up, so the sustained rate is one request
// per cycle; a matching frame passes the input register and then the result
// register before its control word shows on the outputs. Frames whose
// identifier differs from the configured status identifier leave the state
// unchanged and produce no result.
// The two register stages (input and result) set both the latency and the stall
// behavior: the input side keeps accepting while a finished result waits, until
// both stages are full. Configuration writes take effect at once and are meant
// to be made while no request is in flight.
`default_nettype none
`include "drive_control_word_handshake_macros.svh"
module drive_control_word_handshake (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dcwh_pkg::IdW-1:0]      frame_id_i,
  input  wire logic [dcwh_pkg::ByteW-1:0]    status_low_i,
  input  wire logic [dcwh_pkg::ByteW-1:0]    status_high_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [dcwh_pkg::ByteW-1:0]         control_low_o,
  output logic [dcwh_pkg::ByteW-1:0]         control_high_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [0:0]                    cfg_index_i,
  input  wire logic [dcwh_pkg::CfgDataW-1:0] cfg_wdata_i
);

  dcwh_pkg::cfg_t       cfg;
  dcwh_pkg::drv_state_t state_q, state_d;

  logic                         in_valid_q;
  logic [dcwh_pkg::IdW-1:0]     id_q;
  logic [dcwh_pkg::ByteW-1:0]   status_q;
  logic                         out_valid_q, out_valid_d;
  logic [dcwh_pkg::ByteW-1:0]   ctl_low_q, ctl_high_q;
  logic                         advance, match, load_match, in_take;

  dcwh_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dcwh_decide u_decide (
    .state_i          (state_q),
    .status_i         (status_q),
    .ready_to_drive_i (cfg.ready_to_drive),
    .state_o          (state_d)
  );

  // Handshake control: the result stage moves when it is empty or drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign match      = (id_q == cfg.status_frame_id);
  assign load_match = in_valid_q && advance && match;
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;
  assign out_valid_d = advance ? (in_valid_q && match) : out_valid_q;

  // Control registers: stage valids and command state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      if (load_match) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers of the input stage. The high status byte plays no part.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      id_q     <= frame_id_i;
      status_q <= status_low_i;
    end
  end

  // Result register holds the packed control word.
  always_ff @(posedge clk_i) begin
    if (load_match) begin
      ctl_low_q  <= dcwh_pkg::pack_low(state_d.cmd);
      ctl_high_q <= dcwh_pkg::pack_high(state_d.cmd);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign control_low_o  = ctl_low_q;
  assign control_high_o = ctl_high_q;

  // Every processed matching frame flips the toggle bit.
  `DCWH_ASSERT_NEXT(a_toggle_flips, clk_i, rst_ni, load_match,
    state_q.cmd[dcwh_pkg::CmdToggle] != $past(state_q.cmd[dcwh_pkg::CmdToggle]))
  // State moves only with a matching frame.
  `DCWH_ASSERT_NEXT(a_state_holds, clk_i, rst_ni, !load_match, $stable(state_q))
  // A pending fault is acknowledged on the next matching frame.
  `DCWH_ASSERT_NEXT(a_fault_ack, clk_i, rst_ni, load_match && state_q.fault_pending,
    !state_q.fault_pending && !state_q.cmd[dcwh_pkg::CmdDrive])
  // A waiting result always matches the command state.
  `DCWH_ASSERT_NOW(a_result_matches, clk_i, rst_ni, out_valid_q,
    (ctl_low_q == dcwh_pkg::pack_low(state_q.cmd)) &&
    (ctl_high_q == dcwh_pkg::pack_high(state_q.cmd)))

endmodule
`default_nettype wire

### tb/drive_control_word_handshake_test.sv
// Self-checking testbench for the drive control-word handshake block.
`default_nettype none
module drive_control_word_handshake_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned SettleCycles = 8;
  localparam logic [dcwh_pkg::IdW-1:0] SId = dcwh_pkg::StatusIdReset;

  // One control word as the block returns it.
  typedef struct packed {
    logic [dcwh_pkg::ByteW-1:0] lo;
    logic [dcwh_pkg::ByteW-1:0] hi;
  } ctrl_word_t;

  // One row of the directed stimulus; typed rows carry a hand-written control word.
  typedef struct packed {
    logic [dcwh_pkg::IdW-1:0]   id;
    logic [dcwh_pkg::ByteW-1:0] st_lo;
    logic [dcwh_pkg::ByteW-1:0] st_hi;
    logic                       rtd;
    logic                       typed;
    logic [dcwh_pkg::ByteW-1:0] ctl_lo;
    logic [dcwh_pkg::ByteW-1:0] ctl_hi;
  } dir_row_t;

  localparam int unsigned NumDirRows = 25;
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{SId,     8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'h80}, // first frame after reset
    '{11'h000, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00}, // foreign identifier, low end
    '{11'h7FF, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00}, // foreign identifier, high end
    '{SId,     8'h08, 8'hFF, 1'b0, 1'b1, 8'h80, 8'h00}, // fault raised
    '{SId,     8'hFF, 8'h00, 1'b0, 1'b1, 8'h00, 8'h80}, // pending fault acknowledged
    '{SId,     8'h40, 8'hA5, 1'b0, 1'b1, 8'h06, 8'h00}, // switch-on inhibit
    '{SId,     8'h30, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00}, // not ready
    '{SId,     8'h31, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00}, // ready to switch on, not allowed
    '{SId,     8'h33, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00}, // ready
    '{SId,     8'h37, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00}, // operation enabled
    '{SId,     8'h31, 8'h5A, 1'b0, 1'b0, 8'h00, 8'h00}, // back to ready to switch on
    '{11'h180, 8'h33, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00}, // identifier off by one bit
    '{SId,     8'h70, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00}, // inhibit with off bits set
    '{SId,     8'h10, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00}, // unmatched pattern
    '{SId,     8'hB7, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00}, // warning bit is ignored
    '{SId,     8'h35, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00}, // enabled without ready
    '{SId,     8'h41, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00}, // inhibit with power-up ready
    '{SId,     8'h37, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00}, // operation enabled, drive allowed
    '{SId,     8'h31, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00}, // switch-on allowed, drive kept
    '{SId,     8'h30, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00}, // not ready drops drive
    '{SId,     8'h31, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00}, // switch-on allowed, no drive
    '{SId,     8'h08, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00}, // fault raised
    '{SId,     8'h08, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00}, // fault bit ignored while pending
    '{SId,     8'h7F, 8'hFF, 1'b1, 1'b0, 8'h00, 8'h00}, // all status bits set
    '{SId,     8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00}  // pending fault acknowledged
  };

  localparam int unsigned NumPhases = 8;
  localparam int unsigned ItemsPerPhase = 225;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [dcwh_pkg::IdW-1:0]      frame_id_i = '0;
  logic [dcwh_pkg::ByteW-1:0]    status_low_i = '0;
  logic [dcwh_pkg::ByteW-1:0]    status_high_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [dcwh_pkg::ByteW-1:0]    control_low_o;
  logic [dcwh_pkg::ByteW-1:0]    control_high_o;
  logic                          cfg_we_i = 1'b0;
  logic [0:0]                    cfg_index_i = '0;
  logic [dcwh_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  // Predicted drive state and the configuration it runs under.
  logic [dcwh_pkg::IdW-1:0]  cfg_status_id = dcwh_pkg::StatusIdReset;
  logic                      cfg_rtd = 1'b0;
  logic [dcwh_pkg::CmdW-1:0] drive_cmd = '0;
  logic                      fault_flag = 1'b0;

  ctrl_word_t ctrl_expected [$];

  int unsigned errors = 0;
  int unsigned frames_sent = 0;
  int unsigned words_checked = 0;
  int unsigned cycle_cnt = 0;
  int unsigned rx_hold = 0;
  logic        tx_gaps_on = 1'b1;
  logic        rx_stall_on = 1'b1;

  drive_control_word_handshake u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .frame_id_i     (frame_id_i),
    .status_low_i   (status_low_i),
    .status_high_i  (status_high_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .control_low_o  (control_low_o),
    .control_high_o (control_high_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Free-running clock.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Run-length watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("drive_control_word_handshake test failed");
      $finish;
    end
  end

  // Advances the predicted command bits for one matching status frame.
  function automatic ctrl_word_t step_command(input logic [dcwh_pkg::ByteW-1:0] st);
    logic [dcwh_pkg::CmdW-1:0] c;
    logic                      pur, rdy, ope, flt, inh, offs_ok;
    ctrl_word_t                w;
    pur = st[dcwh_pkg::StPowerUp];
    rdy = st[dcwh_pkg::StReady];
    ope = st[dcwh_pkg::StOpEn];
    flt = st[dcwh_pkg::StFault];
    inh = st[dcwh_pkg::StInhibit];
    offs_ok = st[dcwh_pkg::StNoOff2] && st[dcwh_pkg::StNoOff3];
    c = drive_cmd;
    c[dcwh_pkg::CmdToggle] = ~c[dcwh_pkg::CmdToggle];
    if (fault_flag) begin
      c[dcwh_pkg::CmdReset] = ~c[dcwh_pkg::CmdReset];
      c[dcwh_pkg::CmdDrive] = 1'b0;
      fault_flag = 1'b0;
    end else if (flt) begin
      c[dcwh_pkg::CmdReset] = ~c[dcwh_pkg::CmdReset];
      c[dcwh_pkg::CmdOn] = 1'b0;
      c[dcwh_pkg::CmdOff2] = 1'b0;
      c[dcwh_pkg::CmdOff3] = 1'b0;
      c[dcwh_pkg::CmdEnable] = 1'b0;
      c[dcwh_pkg::CmdDrive] = 1'b0;
      fault_flag = 1'b1;
    end else if (!pur && !rdy && !ope && (inh || offs_ok)) begin
      // Switch-on inhibit and not ready both leave the drive switched off.
      c[dcwh_pkg::CmdOff2] = 1'b1;
      c[dcwh_pkg::CmdOff3] = 1'b1;
      c[dcwh_pkg::CmdOn] = 1'b0;
      c[dcwh_pkg::CmdDrive] = 1'b0;
    end else if (!inh && pur && !rdy && !ope && offs_ok) begin
      c[dcwh_pkg::CmdOff2] = 1'b1;
      c[dcwh_pkg::CmdOff3] = 1'b1;
      if (cfg_rtd) begin
        c[dcwh_pkg::CmdOn] = 1'b1;
      end else begin
        c[dcwh_pkg::CmdOn] = 1'b0;
        c[dcwh_pkg::CmdDrive] = 1'b0;
      end
    end else if (!inh && pur && rdy && offs_ok) begin
      c[dcwh_pkg::CmdOn] = 1'b1;
      c[dcwh_pkg::CmdOff2] = 1'b1;
      c[dcwh_pkg::CmdOff3] = 1'b1;
      c[dcwh_pkg::CmdEnable] = 1'b1;
      c[dcwh_pkg::CmdDrive] = 1'b1;
    end
    drive_cmd = c;
    w.lo = {c[dcwh_pkg::CmdReset], 3'b000, c[dcwh_pkg::CmdEnable], c[dcwh_pkg::CmdOff3],
            c[dcwh_pkg::CmdOff2], c[dcwh_pkg::CmdOn]};
    w.hi = {c[dcwh_pkg::CmdToggle], 5'b00000, c[dcwh_pkg::CmdDrive], 1'b0};
    return w;
  endfunction

  // Sender gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!tx_gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Status byte: mostly the recognized drive states, the rest noise.
  function automatic logic [dcwh_pkg::ByteW-1:0] pick_status();
    logic [dcwh_pkg::ByteW-1:0] st;
    st = (dcwh_pkg::ByteW)'($urandom);
    case ($urandom_range(0, 9))
      0: st[dcwh_pkg::StFault] = 1'b1;
      1: begin
        st[3:0] = 4'h0;
        st[dcwh_pkg::StInhibit] = 1'b1;
      end
      2: st[6:0] = 7'h30;
      3, 4: st[6:0] = 7'h31;
      5, 6: begin
        st[6:0] = 7'h33;
        st[dcwh_pkg::StOpEn] = 1'($urandom_range(0, 1));
      end
      default: ;
    endcase
    return st;
  endfunction

  // Presents one request and waits until it is taken.
  task automatic send_frame(input logic [dcwh_pkg::IdW-1:0] id,
                            input logic [dcwh_pkg::ByteW-1:0] st_lo,
                            input logic [dcwh_pkg::ByteW-1:0] st_hi, input logic typed,
                            input ctrl_word_t typed_word);
    ctrl_word_t w;
    in_valid_i <= 1'b1;
    frame_id_i <= id;
    status_low_i <= st_lo;
    status_high_i <= st_hi;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    frames_sent++;
    if (id == cfg_status_id) begin
      w = step_command(st_lo);
      if (typed) w = typed_word;
      ctrl_expected.push_back(w);
    end
  endtask

  // Idles the sender for a random gap before the next request.
  task automatic idle_gap();
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops the sender until every control word is back and the pipe is empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ctrl_expected.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes the status identifier register, then the ready-to-drive register; the block must be idle.
  task automatic write_cfg(input logic [dcwh_pkg::IdW-1:0] id, input logic rtd);
    logic [dcwh_pkg::CfgDataW-2:0] junk;
    junk = (dcwh_pkg::CfgDataW - 1)'($urandom);
    cfg_we_i <= 1'b1;
    cfg_index_i <= dcwh_pkg::CFG_STATUS_ID;
    cfg_wdata_i <= id;
    @(posedge clk_i);
    cfg_status_id = id;
    cfg_index_i <= dcwh_pkg::CFG_READY_TO_DRIVE;
    cfg_wdata_i <= {junk, rtd};
    @(posedge clk_i);
    cfg_rtd = rtd;
    cfg_we_i <= 1'b0;
  endtask

  // Result side: random stalls of random length, or always ready.
  always @(posedge clk_i) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (!rx_stall_on) begin
      out_ready_i <= 1'b1;
    end else if (r < 60) begin
      out_ready_i <= 1'b1;
      rx_hold <= $urandom_range(0, 7);
    end else if (r < 95) begin
      out_ready_i <= 1'b0;
      rx_hold <= $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b0;
      rx_hold <= $urandom_range(9, 39);
    end
  end

  // Compares each delivered control word with the oldest prediction.
  always @(posedge clk_i) begin
    ctrl_word_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (ctrl_expected.size() == 0) begin
        $display("%0t: unexpected control word lo=%h hi=%h", $time, control_low_o,
                 control_high_o);
        errors++;
      end else begin
        w = ctrl_expected.pop_front();
        words_checked++;
        if (control_low_o !== w.lo) begin
          $display("%0t: control_low expected %h actual %h", $time, w.lo, control_low_o);
          errors++;
        end
        if (control_high_o !== w.hi) begin
          $display("%0t: control_high expected %h actual %h", $time, w.hi, control_high_o);
          errors++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random phases under several settings.
  initial begin
    logic [dcwh_pkg::IdW-1:0]   phase_id [NumPhases];
    logic                       phase_rtd [NumPhases];
    logic [dcwh_pkg::IdW-1:0]   id;
    logic [dcwh_pkg::ByteW-1:0] st_hi;
    ctrl_word_t                 tw;
    phase_id = '{SId, 11'h000, 11'h7FF, 11'h555, 11'h2AA, 11'h181, 11'h000, 11'h7FF};
    phase_rtd = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_id[5] = (dcwh_pkg::IdW)'($urandom);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; a change of the switch-on permission waits for an idle block.
    for (int i = 0; i < NumDirRows; i++) begin
      if (DirRows[i].rtd != cfg_rtd) begin
        drain();
        write_cfg(cfg_status_id, DirRows[i].rtd);
      end else begin
        idle_gap();
      end
      tw.lo = DirRows[i].ctl_lo;
      tw.hi = DirRows[i].ctl_hi;
      send_frame(DirRows[i].id, DirRows[i].st_lo, DirRows[i].st_hi, DirRows[i].typed, tw);
    end

    // Random phases, each under its own settings and idling pattern.
    tw = '0;
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_cfg(phase_id[p], phase_rtd[p]);
      tx_gaps_on = (p != 2) && (p != 5);
      rx_stall_on = (p != 2) && (p != 6);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (n == ItemsPerPhase / 2) begin
          drain();
        end else begin
          idle_gap();
        end
        id = ($urandom_range(0, 3) != 0) ? cfg_status_id : (dcwh_pkg::IdW)'($urandom);
        st_hi = (dcwh_pkg::ByteW)'($urandom);
        send_frame(id, pick_status(), st_hi, 1'b0, tw);
      end
    end

    // Let the last results drain, then report.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ctrl_expected.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d status frames over %0d register settings; checked %0d control words.",
             frames_sent, NumPhases + 1, words_checked);
    $display("Mismatches found: %0d.", errors);
    if (errors == 0) begin
      $display("drive_control_word_handshake test passed");
    end else begin
      $display("drive_control_word_handshake test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### drive_control_word_handshake.f
+incdir+hdl
hdl/dcwh_pkg.sv
hdl/dcwh_cfg.sv
hdl/dcwh_decide.sv
hdl/drive_control_word_handshake.sv
tb/drive_control_word_handshake_test.sv
